// File: src/usb_audio_packetizer_assert.svh
// Assertion macros shared by the packetizer checker.
`ifndef USB_AUDIO_PACKETIZER_ASSERT_SVH
`define USB_AUDIO_PACKETIZER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define UAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define UAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/uap_pkg.sv
// Shared constants, codes and interface types of the audio packetizer.
`default_nettype none
package uap_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W      = FIFO_CW + 1;

  localparam int STAGE_MAX = 48;
  localparam int STAGE_AW  = $clog2(STAGE_MAX);

  localparam int SAMPLE_W   = 32;
  localparam int HZ_W       = 16;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 3;

  localparam logic [STAGE_AW-1:0] PKT_SIZE_48K  = STAGE_AW'(48);
  localparam logic [STAGE_AW-1:0] PKT_SIZE_LONG = STAGE_AW'(45);
  localparam logic [STAGE_AW-1:0] PKT_SIZE_SHRT = STAGE_AW'(44);
  localparam logic [3:0]          PHASE_LAST    = 4'd9;

  localparam logic [HZ_W-1:0] HZ_48K = 16'd48000;
  localparam logic [HZ_W-1:0] HZ_44K = 16'd44100;

  typedef logic [1:0] rate_t;
  localparam rate_t RATE_48K  = 2'd0;
  localparam rate_t RATE_44K  = 2'd1;
  localparam rate_t ACC_NONE  = 2'd2;
  localparam rate_t HOST_NONE = 2'd3;

  typedef logic [2:0] action_t;
  localparam action_t ACT_PUSH = 3'd0;
  localparam action_t ACT_TICK = 3'd1;
  localparam action_t ACT_PLAY = 3'd2;
  localparam action_t ACT_HOST = 3'd3;
  localparam action_t ACT_ACC  = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_UNSUPPORTED = 2'd1;
  localparam status_t ST_IGNORED     = 2'd2;
  localparam status_t ST_FULL        = 2'd3;

  typedef struct packed {
    logic                fifo_we;
    logic [FIFO_AW-1:0]  fifo_waddr;
    logic [SAMPLE_W-1:0] fifo_wdata;
    logic                fifo_re;
    logic [FIFO_AW-1:0]  fifo_raddr;
    logic                stage_we;
    logic [STAGE_AW-1:0] stage_waddr;
    logic [SAMPLE_W-1:0] stage_wdata;
    logic                stage_re;
    logic [STAGE_AW-1:0] stage_raddr;
  } store_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] fifo_rdata;
    logic [SAMPLE_W-1:0] stage_rdata;
  } store_rsp_t;

endpackage
`default_nettype wire

// File: src/uap_store.sv
// Sample FIFO memory and packet staging memory, both with registered reads.
`default_nettype none
module uap_store (
  input  wire logic               clk,
  input  wire uap_pkg::store_req_t req,
  output uap_pkg::store_rsp_t      rsp
);

  logic [uap_pkg::SAMPLE_W-1:0] fifo_mem  [uap_pkg::FIFO_DEPTH];
  logic [uap_pkg::SAMPLE_W-1:0] stage_mem [uap_pkg::STAGE_MAX];
  logic [uap_pkg::SAMPLE_W-1:0] fifo_rdata_r;
  logic [uap_pkg::SAMPLE_W-1:0] stage_rdata_r;

  always_ff @(posedge clk) begin
    if (req.fifo_we) begin
      fifo_mem[req.fifo_waddr] <= req.fifo_wdata;
    end
    // hold read data when no read is issued
    if (req.fifo_re) begin
      fifo_rdata_r <= fifo_mem[req.fifo_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.stage_we) begin
      stage_mem[req.stage_waddr] <= req.stage_wdata;
    end
    if (req.stage_re) begin
      stage_rdata_r <= stage_mem[req.stage_raddr];
    end
  end

  assign rsp.fifo_rdata  = fifo_rdata_r;
  assign rsp.stage_rdata = stage_rdata_r;

endmodule
`default_nettype wire

// File: src/uap_ctrl.sv
// Sequencer of the packetizer: FIFO pointers, rate state, packet forming and result register.
`default_nettype none
module uap_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [uap_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [uap_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [uap_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast,
  output logic [uap_pkg::OUT_USER_W-1:0]        out_tuser,
  output uap_pkg::store_req_t                   mem_req,
  input  wire uap_pkg::store_rsp_t              mem_rsp
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EMIT_RD = 6'b000010,
    S_EMIT_WR = 6'b000100,
    S_XFER_RD = 6'b001000,
    S_XFER_WR = 6'b010000,
    S_SILENCE = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [uap_pkg::FIFO_AW-1:0]    rp_r, rp_nxt;
  logic [uap_pkg::FIFO_AW-1:0]    wp_r, wp_nxt;
  logic [uap_pkg::FIFO_CW-1:0]    fill_r, fill_nxt;
  logic                           exh_r, exh_nxt;
  uap_pkg::rate_t                 host_r, host_nxt;
  uap_pkg::rate_t                 acc_r, acc_nxt;
  logic [3:0]                     phase_r, phase_nxt;
  logic                           attr_r, attr_nxt;
  logic [uap_pkg::STAGE_AW-1:0]   staged_r, staged_nxt;
  logic [uap_pkg::STAGE_AW-1:0]   size_r, size_nxt;
  logic [uap_pkg::STAGE_AW-1:0]   idx_r, idx_nxt;
  logic                           src_r, src_nxt;

  logic                           ovalid_r, ovalid_nxt;
  logic [uap_pkg::SAMPLE_W-1:0]   odata_r, odata_nxt;
  logic                           olast_r, olast_nxt;
  logic                           osilent_r, osilent_nxt;
  uap_pkg::status_t               ostatus_r, ostatus_nxt;

  logic                           out_free;
  logic                           accept;
  uap_pkg::action_t               act;
  logic [uap_pkg::SAMPLE_W-1:0]   in_sample;
  logic                           in_rate;
  logic [uap_pkg::HZ_W-1:0]       in_hz;
  logic [uap_pkg::STAGE_AW-1:0]   tick_size;
  logic [uap_pkg::SUM_W-1:0]      avail;
  logic                           enough;
  logic                           do_issue;
  logic [uap_pkg::STAGE_AW-1:0]   rd_idx;
  logic                           is_last;

  assign act       = in_tuser;
  assign in_sample = in_tdata[uap_pkg::SAMPLE_W-1:0];
  assign in_rate   = in_tdata[uap_pkg::SAMPLE_W];
  assign in_hz     = in_tdata[uap_pkg::SAMPLE_W+uap_pkg::HZ_W:uap_pkg::SAMPLE_W+1];

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign tick_size = (acc_r == uap_pkg::RATE_48K) ? uap_pkg::PKT_SIZE_48K :
                     ((phase_r == 4'd0) ? uap_pkg::PKT_SIZE_LONG : uap_pkg::PKT_SIZE_SHRT);
  assign avail     = uap_pkg::SUM_W'(staged_r) + uap_pkg::SUM_W'(fill_r);
  assign enough    = avail >= uap_pkg::SUM_W'(tick_size);
  assign is_last   = (idx_r == size_r - uap_pkg::STAGE_AW'(1));

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    exh_nxt     = exh_r;
    host_nxt    = host_r;
    acc_nxt     = acc_r;
    phase_nxt   = phase_r;
    attr_nxt    = attr_r;
    staged_nxt  = staged_r;
    size_nxt    = size_r;
    idx_nxt     = idx_r;
    src_nxt     = src_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    odata_nxt   = odata_r;
    olast_nxt   = olast_r;
    osilent_nxt = osilent_r;
    ostatus_nxt = ostatus_r;
    do_issue    = 1'b0;
    rd_idx      = idx_r;
    mem_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // single acknowledgement for every action but the tick and the unknown actions
          odata_nxt   = '0;
          olast_nxt   = 1'b1;
          osilent_nxt = 1'b0;
          ostatus_nxt = uap_pkg::ST_OK;
          case (act)
            uap_pkg::ACT_PUSH: begin
              ovalid_nxt = 1'b1;
              if (fill_r == uap_pkg::FIFO_CW'(uap_pkg::FIFO_DEPTH)) begin
                ostatus_nxt = uap_pkg::ST_FULL;
              end else begin
                mem_req.fifo_we    = 1'b1;
                mem_req.fifo_waddr = wp_r;
                mem_req.fifo_wdata = in_sample;
                wp_nxt   = (wp_r == uap_pkg::FIFO_AW'(uap_pkg::FIFO_DEPTH - 1)) ?
                           '0 : wp_r + uap_pkg::FIFO_AW'(1);
                fill_nxt = fill_r + uap_pkg::FIFO_CW'(1);
              end
            end
            uap_pkg::ACT_TICK: begin
              size_nxt  = tick_size;
              idx_nxt   = '0;
              phase_nxt = (phase_r >= uap_pkg::PHASE_LAST) ? 4'd0 : phase_r + 4'd1;
              if (exh_r || (acc_r != host_r)) begin
                state_nxt = S_SILENCE;
              end else if (enough) begin
                state_nxt = S_EMIT_RD;
              end else begin
                // underrun: move what is left into staging, then send silence
                exh_nxt   = 1'b1;
                state_nxt = (fill_r == '0) ? S_SILENCE : S_XFER_RD;
              end
            end
            uap_pkg::ACT_PLAY: begin
              ovalid_nxt = 1'b1;
              exh_nxt    = 1'b0;
              if (!attr_r) begin
                host_nxt = uap_pkg::rate_t'(in_rate);
                attr_nxt = 1'b1;
              end
            end
            uap_pkg::ACT_HOST: begin
              ovalid_nxt = 1'b1;
              host_nxt   = uap_pkg::rate_t'(in_rate);
              attr_nxt   = 1'b1;
            end
            uap_pkg::ACT_ACC: begin
              ovalid_nxt = 1'b1;
              if (in_hz == uap_pkg::HZ_48K) begin
                if (host_r == uap_pkg::RATE_44K) begin
                  ostatus_nxt = uap_pkg::ST_IGNORED;
                end else begin
                  acc_nxt = uap_pkg::RATE_48K;
                end
              end else if (in_hz == uap_pkg::HZ_44K) begin
                if (host_r == uap_pkg::RATE_48K) begin
                  ostatus_nxt = uap_pkg::ST_IGNORED;
                end else begin
                  acc_nxt = uap_pkg::RATE_44K;
                end
              end else begin
                ostatus_nxt = uap_pkg::ST_UNSUPPORTED;
              end
            end
            default: begin
              // unknown actions: drop without a result
            end
          endcase
        end
      end
      S_EMIT_RD: begin
        do_issue  = 1'b1;
        rd_idx    = '0;
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          odata_nxt   = src_r ? mem_rsp.stage_rdata : mem_rsp.fifo_rdata;
          olast_nxt   = is_last;
          osilent_nxt = 1'b0;
          ostatus_nxt = uap_pkg::ST_OK;
          if (is_last) begin
            staged_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt  = idx_r + uap_pkg::STAGE_AW'(1);
            rd_idx   = idx_r + uap_pkg::STAGE_AW'(1);
            do_issue = 1'b1;
          end
        end
      end
      S_XFER_RD: begin
        mem_req.fifo_re    = 1'b1;
        mem_req.fifo_raddr = rp_r;
        rp_nxt   = (rp_r == uap_pkg::FIFO_AW'(uap_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rp_r + uap_pkg::FIFO_AW'(1);
        fill_nxt = fill_r - uap_pkg::FIFO_CW'(1);
        state_nxt = S_XFER_WR;
      end
      S_XFER_WR: begin
        mem_req.stage_we    = 1'b1;
        mem_req.stage_waddr = staged_r;
        mem_req.stage_wdata = mem_rsp.fifo_rdata;
        staged_nxt = staged_r + uap_pkg::STAGE_AW'(1);
        state_nxt  = (fill_r == '0) ? S_SILENCE : S_XFER_RD;
      end
      S_SILENCE: begin
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          odata_nxt   = '0;
          olast_nxt   = is_last;
          osilent_nxt = 1'b1;
          ostatus_nxt = uap_pkg::ST_OK;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + uap_pkg::STAGE_AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // packet word read: staged words first, then pop the FIFO
    if (do_issue) begin
      if (rd_idx < staged_r) begin
        src_nxt             = 1'b1;
        mem_req.stage_re    = 1'b1;
        mem_req.stage_raddr = rd_idx;
      end else begin
        src_nxt            = 1'b0;
        mem_req.fifo_re    = 1'b1;
        mem_req.fifo_raddr = rp_r;
        rp_nxt   = (rp_r == uap_pkg::FIFO_AW'(uap_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rp_r + uap_pkg::FIFO_AW'(1);
        fill_nxt = fill_r - uap_pkg::FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rp_r     <= '0;
      wp_r     <= '0;
      fill_r   <= '0;
      exh_r    <= 1'b1;
      host_r   <= uap_pkg::HOST_NONE;
      acc_r    <= uap_pkg::ACC_NONE;
      phase_r  <= 4'd0;
      attr_r   <= 1'b0;
      staged_r <= '0;
      size_r   <= '0;
      idx_r    <= '0;
      src_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      exh_r    <= exh_nxt;
      host_r   <= host_nxt;
      acc_r    <= acc_nxt;
      phase_r  <= phase_nxt;
      attr_r   <= attr_nxt;
      staged_r <= staged_nxt;
      size_r   <= size_nxt;
      idx_r    <= idx_nxt;
      src_r    <= src_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r   <= odata_nxt;
    olast_r   <= olast_nxt;
    osilent_r <= osilent_nxt;
    ostatus_r <= ostatus_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {ostatus_r, osilent_r};

endmodule
`default_nettype wire

// File: src/usb_audio_packetizer.sv
// Top level of the isochronous audio packetizer for 48 kHz and 44.1 kHz stereo streams.
//
// Stereo 16-bit sample words are pushed into a FIFO and on each 1 ms frame tick one
// packet goes out, its final word marked by out_tlast: 48 words at 48 kHz, and at
// 44.1 kHz 45 words every tenth packet and 44 otherwise. Silence (zero words,
// silent flag set) is sent when the source is exhausted, when the FIFO runs dry
// before the packet is complete (the words already taken are kept in a staging
// memory for a later packet), or when host and accessory rates differ. Every other
// action (push, play start, host rate select, accessory rate set) answers with one
// acknowledgement transfer carrying a status; actions 5 to 7 are dropped silently.
// Timing: a new transfer is taken every cycle while the result side keeps up. A frame
// tick holds the input until its packet is sent: a sample packet first issues a memory
// read, then emits one word per memory read; a silence packet emits zero words; on an
// underrun the FIFO words are first moved into staging, each with a read and a write.
// A stall on the result side lengthens the hold. Each memory has a single read port.
// The sample FIFO and the staging memory need no clearing after reset.
`default_nettype none
module usb_audio_packetizer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // sample [31:0], rate_index [32], sample_rate_hz [48:33], zero fill [55:49]
  input  wire logic [uap_pkg::IN_DATA_W-1:0]     in_tdata,
  // action [2:0]
  input  wire logic [uap_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // sample_out [31:0]
  output logic [uap_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tlast,
  // silent [0], status [2:1]
  output logic [uap_pkg::OUT_USER_W-1:0]         out_tuser
);

  uap_pkg::store_req_t mem_req;
  uap_pkg::store_rsp_t mem_rsp;

  // Sequencer: owns pointers, flags, packet counter and the result register.
  uap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mem_req    (mem_req),
    .mem_rsp    (mem_rsp)
  );

  // Sample FIFO and staging memories.
  uap_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule
`default_nettype wire

// File: src/uap_checker.sv
// Port-level checker of the audio packetizer and its bind to the top level.
`default_nettype none
`include "usb_audio_packetizer_assert.svh"
module uap_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [uap_pkg::IN_DATA_W-1:0]     in_tdata,
  input wire logic [uap_pkg::IN_USER_W-1:0]     in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [uap_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic                              out_tlast,
  input wire logic [uap_pkg::OUT_USER_W-1:0]    out_tuser
);

  logic tick_taken;
  assign tick_taken = in_tvalid && in_tready && (in_tuser == uap_pkg::ACT_TICK)
                      && (in_tdata == in_tdata);

  // a stalled result holds
  `UAP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  // a nonzero status only on a lone acknowledgement
  `UAP_ASSERT_IMPLY(a_status_ack, clk, rst_n, out_tvalid && (out_tuser[2:1] != uap_pkg::ST_OK), out_tlast && !out_tuser[0] && (out_tdata == '0), "bad acknowledgement")
  // silence words carry zero data and status
  `UAP_ASSERT_IMPLY(a_silent_zero, clk, rst_n, out_tvalid && out_tuser[0], (out_tdata == '0) && (out_tuser[2:1] == uap_pkg::ST_OK), "silence word not zero")
  // a frame tick occupies the block for at least the next cycle
  `UAP_ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_taken, !in_tready, "input ready right after tick")

endmodule

bind usb_audio_packetizer uap_checker u_uap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// File: dv/usb_audio_packetizer_tb.sv
// Self-checking testbench of the audio packetizer: directed table, random episodes, scoreboard.
`default_nettype none
module usb_audio_packetizer_tb;
  import uap_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] word;
    logic                last;
    logic                silent;
    status_t             status;
  } pkt_word_t;

  typedef struct {
    action_t             act;
    logic [SAMPLE_W-1:0] smp;
    logic                ri;
    logic [HZ_W-1:0]     hz;
    bit                  typed;
    status_t             st;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [OUT_USER_W-1:0] out_tuser;

  usb_audio_packetizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Packetizer state as the testbench sees it
  logic [SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  rd_ptr = '0;
  logic [FIFO_AW-1:0]  wr_ptr = '0;
  int                  fifo_level = 0;
  bit                  dry = 1'b1;
  rate_t               host_sel = HOST_NONE;
  rate_t               acc_sel = ACC_NONE;
  int                  phase_cnt = 0;
  bit                  attr_done = 1'b0;
  logic [SAMPLE_W-1:0] stage_mem [STAGE_MAX];
  int                  stage_cnt = 0;

  pkt_word_t expected_q [$];
  stim_row_t stim_rows [$];

  bit      typed_ack = 1'b0;
  status_t typed_status = ST_OK;
  bit      tx_calm = 1'b0;
  bit      rx_calm = 1'b0;

  int n_accepted = 0;
  int sent_items = 0;
  int n_words = 0;
  int n_mismatch = 0;
  int cycles = 0;
  int n_live = 0;
  int n_silent = 0;
  int n_underrun = 0;
  int n_trim = 0;
  int n_status [4] = '{0, 0, 0, 0};

  function automatic int packet_len();
    if (acc_sel == RATE_48K) return int'(PKT_SIZE_48K);
    return (phase_cnt == 0) ? int'(PKT_SIZE_LONG) : int'(PKT_SIZE_SHRT);
  endfunction

  function automatic void ack(status_t st);
    expected_q.push_back('{word: '0, last: 1'b1, silent: 1'b0, status: st});
    n_status[st]++;
  endfunction

  // Frame tick: stage words from the FIFO, then send them or a silence packet
  function automatic void emit_packet();
    int len;
    int i;
    len = packet_len();
    phase_cnt = (phase_cnt == int'(PHASE_LAST)) ? 0 : phase_cnt + 1;
    if (!dry && acc_sel == host_sel) begin
      if (stage_cnt >= len) n_trim++;
      while (stage_cnt < len && fifo_level > 0) begin
        stage_mem[stage_cnt] = fifo_mem[rd_ptr];
        rd_ptr++;
        fifo_level--;
        stage_cnt++;
      end
      if (stage_cnt >= len) begin
        for (i = 0; i < len; i++)
          expected_q.push_back('{word: stage_mem[i], last: (i == len - 1), silent: 1'b0,
                                 status: ST_OK});
        stage_cnt = 0;
        n_live++;
        return;
      end
      // underrun: keep staged words for a later packet
      dry = 1'b1;
      n_underrun++;
    end
    for (i = 0; i < len; i++)
      expected_q.push_back('{word: '0, last: (i == len - 1), silent: 1'b1, status: ST_OK});
    n_silent++;
  endfunction

  function automatic void packetizer_step(action_t act, logic [SAMPLE_W-1:0] smp, logic ri,
                                          logic [HZ_W-1:0] hz);
    rate_t idx;
    case (act)
      ACT_PUSH: begin
        if (fifo_level >= FIFO_DEPTH) begin
          ack(ST_FULL);
        end else begin
          fifo_mem[wr_ptr] = smp;
          wr_ptr++;
          fifo_level++;
          ack(ST_OK);
        end
      end
      ACT_TICK: emit_packet();
      ACT_PLAY: begin
        dry = 1'b0;
        if (!attr_done) begin
          host_sel = rate_t'(ri);
          attr_done = 1'b1;
        end
        ack(ST_OK);
      end
      ACT_HOST: begin
        host_sel = rate_t'(ri);
        attr_done = 1'b1;
        ack(ST_OK);
      end
      ACT_ACC: begin
        if (hz == HZ_48K || hz == HZ_44K) begin
          idx = (hz == HZ_48K) ? RATE_48K : RATE_44K;
          if (host_sel != HOST_NONE && idx != host_sel) begin
            ack(ST_IGNORED);
          end else begin
            acc_sel = idx;
            ack(ST_OK);
          end
        end else begin
          ack(ST_UNSUPPORTED);
        end
      end
      default: ;
    endcase
  endfunction

  // Input acceptance feeds the predictor; output transfers are checked in order
  always @(posedge clk) begin
    pkt_word_t got;
    pkt_word_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, expected_q.size());
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        packetizer_step(action_t'(in_tuser), in_tdata[31:0], in_tdata[32], in_tdata[48:33]);
        if (typed_ack) begin
          // hand-written answer replaces the predicted one
          void'(expected_q.pop_back());
          expected_q.push_back('{word: '0, last: 1'b1, silent: 1'b0, status: typed_status});
        end
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got = '{word: out_tdata, last: out_tlast, silent: out_tuser[0], status: out_tuser[2:1]};
        n_words++;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_LIMIT)
            $display("unexpected transfer out: word %h last %b silent %b status %0d",
                     got.word, got.last, got.silent, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= SHOW_LIMIT)
              $display("mismatch at output transfer %0d: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                       n_words, want.word, want.last, want.silent, want.status,
                       got.word, got.last, got.silent, got.status);
          end
        end
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: stall at random unless told to stay ready
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= rst_n;
        if (!rx_calm && rst_n) hold = idle_len();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send(action_t act, logic [SAMPLE_W-1:0] smp, logic ri, logic [HZ_W-1:0] hz,
                      bit typed = 1'b0, status_t st = ST_OK);
    int gap;
    int seen;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, hz, ri, smp};
    in_tuser  <= act;
    typed_ack = typed;
    typed_status = st;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
    sent_items++;
  endtask

  function automatic logic [HZ_W-1:0] pick_hz();
    case ($urandom_range(0, 3))
      0: return HZ_48K;
      1: return HZ_44K;
      default: return HZ_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic noise_item();
    send(action_t'($urandom_range(0, 7)), $urandom, 1'($urandom), pick_hz());
  endtask

  // Fill the FIFO for the next packet, sometimes short to force an underrun
  task automatic run_frame();
    int want;
    int n;
    if (dry && $urandom_range(0, 4) != 0)
      send(ACT_PLAY, $urandom, 1'($urandom), pick_hz());
    want = packet_len() - stage_cnt - fifo_level;
    case ($urandom_range(0, 9))
      0, 1: n = want - $urandom_range(1, 6);
      2: n = $urandom_range(0, 10);
      default: n = ((want > 0) ? want : 0) + $urandom_range(0, 4);
    endcase
    if (n < 0) n = 0;
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) noise_item();
      send(ACT_PUSH, $urandom, 1'($urandom), HZ_W'($urandom));
    end
    send(ACT_TICK, $urandom, 1'($urandom), HZ_W'($urandom));
  endtask

  // Move host and accessory to a new rate, with an occasional mismatched request
  task automatic change_rate();
    rate_t r;
    r = rate_t'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0)
      send(ACT_ACC, $urandom, 1'($urandom), (r == RATE_48K) ? HZ_44K : HZ_48K);
    send(ACT_HOST, $urandom, r[0], HZ_W'($urandom));
    if ($urandom_range(0, 4) != 0)
      send(ACT_ACC, $urandom, 1'($urandom), (r == RATE_48K) ? HZ_48K : HZ_44K);
  endtask

  // Back-to-back pushes past the FIFO depth
  task automatic fill_fifo();
    tx_calm = 1'b1;
    repeat (FIFO_DEPTH - fifo_level + $urandom_range(1, 4))
      send(ACT_PUSH, $urandom, 1'($urandom), HZ_W'($urandom));
  endtask

  function automatic void row(action_t act, logic [SAMPLE_W-1:0] smp, logic ri,
                              logic [HZ_W-1:0] hz, bit typed = 1'b0, status_t st = ST_OK);
    stim_rows.push_back('{act: act, smp: smp, ri: ri, hz: hz, typed: typed, st: st});
  endfunction

  initial begin
    int ep;
    // action      sample         rate  hz            typed  status
    row(ACT_TICK, 32'h0,         1'b0, 16'd0);                        // no rate yet: silence
    row(ACT_ACC,  32'h0,         1'b0, 16'd0,        1'b1, ST_UNSUPPORTED);
    row(ACT_ACC,  32'h0,         1'b1, 16'hFFFF,     1'b1, ST_UNSUPPORTED);
    row(ACT_ACC,  32'h0,         1'b0, HZ_44K,       1'b1, ST_OK);
    row(ACT_PLAY, 32'h0,         1'b1, 16'd0,        1'b1, ST_OK);   // announces 44.1 kHz
    row(ACT_HOST, 32'h0,         1'b0, 16'd0,        1'b1, ST_OK);
    row(ACT_ACC,  32'h0,         1'b0, HZ_44K,       1'b1, ST_IGNORED);
    row(ACT_HOST, 32'h0,         1'b1, 16'd0,        1'b1, ST_OK);
    row(ACT_PUSH, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,     1'b1, ST_OK);
    row(ACT_PUSH, 32'h0000_0000, 1'b0, 16'd0,        1'b1, ST_OK);
    row(ACT_PUSH, 32'h8000_0001, 1'b1, 16'h8001,     1'b1, ST_OK);
    row(ACT_TICK, 32'h0,         1'b0, 16'd0);                        // underrun, words staged
    row(action_t'(5), 32'hFFFF_FFFF, 1'b1, 16'hFFFF);                 // no answer
    row(action_t'(6), 32'h0,     1'b0, 16'd0);
    row(action_t'(7), 32'h5A5A_A5A5, 1'b1, HZ_48K);
    row(ACT_TICK, 32'h0,         1'b0, 16'd0);                        // exhausted: silence
    row(ACT_PLAY, 32'h0,         1'b0, 16'd0,        1'b1, ST_OK);   // host rate stays
    row(ACT_ACC,  32'h0,         1'b0, HZ_48K,       1'b1, ST_IGNORED);
    row(ACT_PUSH, 32'h7FFF_FFFE, 1'b0, 16'h7FFE,     1'b1, ST_OK);
    row(ACT_HOST, 32'h0,         1'b0, 16'd0,        1'b1, ST_OK);
    row(ACT_ACC,  32'h0,         1'b1, HZ_48K,       1'b1, ST_OK);
    row(ACT_TICK, 32'h0,         1'b0, 16'd0);                        // 48 kHz underrun
    row(ACT_PLAY, 32'h0,         1'b1, 16'd0,        1'b1, ST_OK);
    row(ACT_HOST, 32'h0,         1'b1, 16'd0,        1'b1, ST_OK);
    row(ACT_ACC,  32'h0,         1'b0, HZ_44K,       1'b1, ST_OK);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i])
      send(stim_rows[i].act, stim_rows[i].smp, stim_rows[i].ri, stim_rows[i].hz,
           stim_rows[i].typed, stim_rows[i].st);

    // Random episodes, each with its own idling mix; the first one fills the FIFO
    ep = 0;
    while (sent_items < stim_rows.size() + RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (ep == 0) begin
        fill_fifo();
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: run_frame();
          6, 7: change_rate();
          8: repeat ($urandom_range(1, 6)) noise_item();
          default: send(ACT_TICK, $urandom, 1'($urandom), pick_hz());
        endcase
      end
      ep++;
    end
    in_tvalid <= 1'b0;
    rx_calm = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transfers in, %0d out: %0d sample packets, %0d silence packets, %0d underruns, %0d trimmed",
             sent_items, n_words, n_live, n_silent, n_underrun, n_trim);
    $display("answers ok %0d, unsupported %0d, ignored %0d, fifo full %0d; %0d mismatches",
             n_status[ST_OK], n_status[ST_UNSUPPORTED], n_status[ST_IGNORED],
             n_status[ST_FULL], n_mismatch);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+src
src/uap_pkg.sv
src/uap_store.sv
src/uap_ctrl.sv
src/usb_audio_packetizer.sv
src/uap_checker.sv
dv/usb_audio_packetizer_tb.sv
